// ----- src/evr_pkg.sv -----
// ----------------------------------------------------------------------------
// evr_pkg
// Shared types and constants of the Euler vertex rotator.
// ----------------------------------------------------------------------------
package evr_pkg;

    // trig registers are signed Q2.14
    localparam int TRIG_WIDTH      = 16;
    // one extra bit so that the negated sine of -2.0 still fits
    localparam int TRIG_EXT_WIDTH  = TRIG_WIDTH + 1;

    localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE  = 16'sd16384;
    localparam logic signed [TRIG_WIDTH-1:0] TRIG_ZERO = 16'sd0;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COS_X = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIN_X = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COS_Y = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIN_Y = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COS_Z = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIN_Z = 3'd5;

    // pipeline shape: one cell per axis, two stages per cell
    localparam int NUM_PASSES  = 3;
    localparam int CELL_STAGES = 2;
    localparam int PIPE_DEPTH  = NUM_PASSES * CELL_STAGES;

    // trig coefficients of one pass, already widened and negated
    typedef struct packed {
        logic signed [TRIG_EXT_WIDTH-1:0] cos_v;
        logic signed [TRIG_EXT_WIDTH-1:0] sin_pos;
        logic signed [TRIG_EXT_WIDTH-1:0] sin_neg;
    } evr_trig_t;

endpackage

// ----- src/evr_if.sv -----
// ----------------------------------------------------------------------------
// evr_if
// Valid/ready channels of the rotator: vertex in, vertex out, config write.
// ----------------------------------------------------------------------------

// incoming vertex beats
interface evr_vtx_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
    logic                          last_in;

    modport source (output valid, in_x, in_y, in_z, last_in, input ready);
    modport sink   (input valid, in_x, in_y, in_z, last_in, output ready);
endinterface

// rotated vertex beats
interface evr_rot_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          last_out;

    modport source (output valid, out_x, out_y, out_z, last_out, input ready);
    modport sink   (input valid, out_x, out_y, out_z, last_out, output ready);
endinterface

// register write beats
interface evr_cfg_if import evr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [TRIG_WIDTH-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/evr_rot_cell.sv -----
// ----------------------------------------------------------------------------
// evr_rot_cell
// One rotation pass: p' = p*cos + q*sin_neg, q' = p*sin_pos + q*cos,
// r passes through. Multiply stage, then round/add/saturate stage.
// ----------------------------------------------------------------------------
module evr_rot_cell
    import evr_pkg::*;
#(
    parameter int COORD_WIDTH    = 32,
    parameter int TRIG_FRAC_BITS = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  evr_trig_t                     trig,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic signed [COORD_WIDTH-1:0] up_p,
    input  logic signed [COORD_WIDTH-1:0] up_q,
    input  logic signed [COORD_WIDTH-1:0] up_r,
    input  logic                          up_last,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic signed [COORD_WIDTH-1:0] dn_p,
    output logic signed [COORD_WIDTH-1:0] dn_q,
    output logic signed [COORD_WIDTH-1:0] dn_r,
    output logic                          dn_last
);

    localparam int PW   = COORD_WIDTH + TRIG_EXT_WIDTH;   // product width
    localparam int RW   = PW + 1 - TRIG_FRAC_BITS;        // rounded product width
    localparam int SW   = (RW + 1 > COORD_WIDTH + 1) ? RW + 1 : COORD_WIDTH + 1;
    localparam logic signed [PW:0] BIAS =
        {{(PW + 1 - TRIG_FRAC_BITS){1'b0}}, 1'b1, {(TRIG_FRAC_BITS - 1){1'b0}}};

    // round half up and drop the fraction bits
    function automatic logic signed [SW-1:0] rnd_f(input logic signed [PW-1:0] p);
        logic signed [PW:0] b;
        b = {p[PW-1], p} + BIAS;
        return SW'(b >>> TRIG_FRAC_BITS);
    endfunction

    // clamp to the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] sat_f(
        input logic signed [SW-1:0] v
    );
        logic fits;
        fits = (v[SW-1:COORD_WIDTH-1] == {(SW-COORD_WIDTH+1){1'b0}}) ||
               (v[SW-1:COORD_WIDTH-1] == {(SW-COORD_WIDTH+1){1'b1}});
        if (fits)
            return v[COORD_WIDTH-1:0];
        else if (v[SW-1])
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    endfunction

    logic                          v1_reg, v1_next;
    logic                          v2_reg, v2_next;
    logic                          rdy1, rdy2;
    logic signed [PW-1:0]          prod_pc_reg, prod_qn_reg, prod_ps_reg, prod_qc_reg;
    logic signed [COORD_WIDTH-1:0] r1_reg;
    logic                          last1_reg;
    logic signed [COORD_WIDTH-1:0] p2_reg, q2_reg, r2_reg;
    logic                          last2_reg;
    logic signed [SW-1:0]          sum_p, sum_q;

    // stage handshake: a stage takes a beat when empty or draining
    always_comb
    begin
        rdy2    = !v2_reg || dn_ready;
        rdy1    = !v1_reg || rdy2;
        v1_next = rdy1 ? up_valid : v1_reg;
        v2_next = rdy2 ? v1_reg   : v2_reg;
    end

    assign up_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // stage 1: four products
    always_ff @(posedge clk)
    begin
        if (rdy1 && up_valid)
        begin
            prod_pc_reg <= PW'(up_p) * PW'(trig.cos_v);
            prod_qn_reg <= PW'(up_q) * PW'(trig.sin_neg);
            prod_ps_reg <= PW'(up_p) * PW'(trig.sin_pos);
            prod_qc_reg <= PW'(up_q) * PW'(trig.cos_v);
            r1_reg      <= up_r;
            last1_reg   <= up_last;
        end
    end

    // stage 2: round each product, add pairs, saturate
    always_comb
    begin
        sum_p = rnd_f(prod_pc_reg) + rnd_f(prod_qn_reg);
        sum_q = rnd_f(prod_ps_reg) + rnd_f(prod_qc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            p2_reg    <= sat_f(sum_p);
            q2_reg    <= sat_f(sum_q);
            r2_reg    <= r1_reg;
            last2_reg <= last1_reg;
        end
    end

    assign dn_valid = v2_reg;
    assign dn_p     = p2_reg;
    assign dn_q     = q2_reg;
    assign dn_r     = r2_reg;
    assign dn_last  = last2_reg;

endmodule

// ----- src/euler_vertex_rotator.sv -----
// ----------------------------------------------------------------------------
// euler_vertex_rotator
// Rotates signed fixed-point vertices about z, then y, then x.
// ----------------------------------------------------------------------------
// One vertex beat is accepted every clock while any slot is free; each result
// passes through three rotation cells in a row (z, y, x), each a multiply
// stage and a round/add/saturate stage. The last cell's stage 2 is the output
// register; ready flows back through the chain, so empty slots anywhere keep
// vtx.ready high while a result waits. Cosine and sine registers are Q2.14 and
// reset to the identity rotation; write them only while no vertex is in flight.
// Writes to indexes beyond the six registers are dropped. last_in rides along
// as last_out.
// ----------------------------------------------------------------------------
module euler_vertex_rotator
    import evr_pkg::*;
#(
    parameter int COORD_WIDTH    = 32,
    parameter int TRIG_FRAC_BITS = 14
)
(
    input  logic      clk,
    input  logic      rst_n,
    evr_vtx_if.sink   vtx,
    evr_rot_if.source rot,
    evr_cfg_if.sink   cfg
);

    logic signed [TRIG_WIDTH-1:0] cos_x_reg, sin_x_reg;
    logic signed [TRIG_WIDTH-1:0] cos_y_reg, sin_y_reg;
    logic signed [TRIG_WIDTH-1:0] cos_z_reg, sin_z_reg;
    evr_trig_t                    trig_z, trig_y, trig_x;

    logic                          zy_valid, zy_ready, zy_last;
    logic signed [COORD_WIDTH-1:0] zy_x, zy_y, zy_z;
    logic                          yx_valid, yx_ready, yx_last;
    logic signed [COORD_WIDTH-1:0] yx_x, yx_y, yx_z;

    // register file, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_x_reg <= TRIG_ONE;
            sin_x_reg <= TRIG_ZERO;
            cos_y_reg <= TRIG_ONE;
            sin_y_reg <= TRIG_ZERO;
            cos_z_reg <= TRIG_ONE;
            sin_z_reg <= TRIG_ZERO;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_COS_X: cos_x_reg <= cfg.data;
                REG_SIN_X: sin_x_reg <= cfg.data;
                REG_COS_Y: cos_y_reg <= cfg.data;
                REG_SIN_Y: sin_y_reg <= cfg.data;
                REG_COS_Z: cos_z_reg <= cfg.data;
                REG_SIN_Z: sin_z_reg <= cfg.data;
                default:   ;
            endcase
        end
    end

    // per-pass coefficients; the y pass swaps the sine signs
    always_comb
    begin
        trig_z.cos_v   = TRIG_EXT_WIDTH'(cos_z_reg);
        trig_z.sin_pos = TRIG_EXT_WIDTH'(sin_z_reg);
        trig_z.sin_neg = -TRIG_EXT_WIDTH'(sin_z_reg);
        trig_y.cos_v   = TRIG_EXT_WIDTH'(cos_y_reg);
        trig_y.sin_pos = -TRIG_EXT_WIDTH'(sin_y_reg);
        trig_y.sin_neg = TRIG_EXT_WIDTH'(sin_y_reg);
        trig_x.cos_v   = TRIG_EXT_WIDTH'(cos_x_reg);
        trig_x.sin_pos = TRIG_EXT_WIDTH'(sin_x_reg);
        trig_x.sin_neg = -TRIG_EXT_WIDTH'(sin_x_reg);
    end

    // about z: (p, q, r) = (x, y, z)
    evr_rot_cell #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_cell_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .trig     (trig_z),
        .up_valid (vtx.valid),
        .up_ready (vtx.ready),
        .up_p     (vtx.in_x),
        .up_q     (vtx.in_y),
        .up_r     (vtx.in_z),
        .up_last  (vtx.last_in),
        .dn_valid (zy_valid),
        .dn_ready (zy_ready),
        .dn_p     (zy_x),
        .dn_q     (zy_y),
        .dn_r     (zy_z),
        .dn_last  (zy_last)
    );

    // about y: (p, q, r) = (x, z, y)
    evr_rot_cell #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_cell_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .trig     (trig_y),
        .up_valid (zy_valid),
        .up_ready (zy_ready),
        .up_p     (zy_x),
        .up_q     (zy_z),
        .up_r     (zy_y),
        .up_last  (zy_last),
        .dn_valid (yx_valid),
        .dn_ready (yx_ready),
        .dn_p     (yx_x),
        .dn_q     (yx_z),
        .dn_r     (yx_y),
        .dn_last  (yx_last)
    );

    // about x: (p, q, r) = (y, z, x)
    evr_rot_cell #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_cell_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .trig     (trig_x),
        .up_valid (yx_valid),
        .up_ready (yx_ready),
        .up_p     (yx_y),
        .up_q     (yx_z),
        .up_r     (yx_x),
        .up_last  (yx_last),
        .dn_valid (rot.valid),
        .dn_ready (rot.ready),
        .dn_p     (rot.out_y),
        .dn_q     (rot.out_z),
        .dn_r     (rot.out_x),
        .dn_last  (rot.last_out)
    );

endmodule

// ----- src/evr_checker.sv -----
// ----------------------------------------------------------------------------
// evr_checker
// Port-level checks of the rotator: occupancy, flow and output hold.
// ----------------------------------------------------------------------------
module evr_checker
    import evr_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   vtx_valid,
    input logic                   vtx_ready,
    input logic                   rot_valid,
    input logic                   rot_ready,
    input logic [COORD_WIDTH-1:0] rot_x,
    input logic [COORD_WIDTH-1:0] rot_y,
    input logic [COORD_WIDTH-1:0] rot_z,
    input logic                   rot_last
);

    localparam int CW = $clog2(PIPE_DEPTH + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          beat_in, beat_out;

    // vertices inside the block
    assign beat_in  = vtx_valid && vtx_ready;
    assign beat_out = rot_valid && rot_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (beat_in && !beat_out)
            cnt_next = cnt_reg + CW'(1);
        else if (!beat_in && beat_out)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(PIPE_DEPTH))
        else $error("more vertices in flight than pipeline slots");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid |-> (cnt_reg != '0))
        else $error("result shown with no vertex in flight");

    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg < CW'(PIPE_DEPTH)) |-> vtx_ready)
        else $error("input stalled while a pipeline slot is free");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rot_valid && !rot_ready) |=>
            (rot_valid && $stable(rot_x) && $stable(rot_y) &&
             $stable(rot_z) && $stable(rot_last)))
        else $error("stalled result beat changed");

endmodule

bind euler_vertex_rotator evr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_evr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .vtx_valid (vtx.valid),
    .vtx_ready (vtx.ready),
    .rot_valid (rot.valid),
    .rot_ready (rot.ready),
    .rot_x     (rot.out_x),
    .rot_y     (rot.out_y),
    .rot_z     (rot.out_z),
    .rot_last  (rot.last_out)
);
